### src/audio_fifo_with_stereo_gain_assert.svh
// assertion macros shared by the checker of the pcm fifo block
`ifndef AUDIO_FIFO_WITH_STEREO_GAIN_ASSERT_SVH
`define AUDIO_FIFO_WITH_STEREO_GAIN_ASSERT_SVH

// same-cycle implication, quiet during reset
`define AFG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, quiet during reset
`define AFG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// next-cycle implication that also covers the reset cycles
`define AFG_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### src/afg_pkg.sv
// shared types, widths and constants of the pcm fifo block
package afg_pkg;

  // default sizing
  localparam int FIFO_DEPTH_DEF = 65536;
  localparam int MAX_BURST_DEF  = 64;

  // field widths
  localparam int ACTION_W   = 2;
  localparam int BYTE_W     = 8;
  localparam int FRAMES_W   = 7;
  localparam int SAMPLE_W   = 16;
  localparam int GAIN_W     = 16;
  localparam int CHAN_W     = 2;
  localparam int RATE_W     = 18;
  localparam int LEVEL_W    = 16;
  localparam int MS_W       = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 18;

  // arithmetic
  localparam int PROD_W     = 64;
  localparam int STEP_W     = 17;
  localparam int MS_PER_S   = 1000;
  localparam int UNITY_FRAC = 14;
  localparam int GPROD_W    = 33;
  localparam int SAT_MAX    = 32767;
  localparam int SAT_MIN    = -32768;

  // register reset values
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(16384);
  localparam logic [CHAN_W-1:0] CHAN_RESET = CHAN_W'(2);
  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(48000);

  typedef enum logic [ACTION_W-1:0] {
    ACT_WRITE = 2'd0,
    ACT_PULL  = 2'd1,
    ACT_FLUSH = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_LEFT   = 2'd0,
    REG_GAIN_RIGHT  = 2'd1,
    REG_CHANNELS    = 2'd2,
    REG_SAMPLE_RATE = 2'd3
  } cfg_reg_t;

  // divider control and status
  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] dividend;
    logic [RATE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [MS_W-1:0] quotient;
  } div_rsp_t;

  // gain unit control and status
  typedef struct packed {
    logic                       valid;
    logic signed [SAMPLE_W-1:0] sample;
    logic [GAIN_W-1:0]          gain;
  } gain_req_t;

  typedef struct packed {
    logic                       valid;
    logic signed [SAMPLE_W-1:0] value;
  } gain_rsp_t;

endpackage

### src/afg_if.sv
// handshake channels of the pcm fifo block: command, result and register write

interface afg_cmd_if import afg_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [BYTE_W-1:0]   write_byte;
  logic [FRAMES_W-1:0] frame_count;

  modport source (output valid, action, write_byte, frame_count, input ready);
  modport sink (input valid, action, write_byte, frame_count, output ready);
  modport monitor (input valid, ready, action, write_byte, frame_count);
endinterface

interface afg_res_if import afg_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       accepted;
  logic signed [SAMPLE_W-1:0] left_sample;
  logic signed [SAMPLE_W-1:0] right_sample;
  logic                       burst_last;
  logic                       underrun;
  logic [LEVEL_W-1:0]         fifo_level;
  logic [MS_W-1:0]            playback_ms;

  modport source (output valid, accepted, left_sample, right_sample, burst_last, underrun,
                  fifo_level, playback_ms, input ready);
  modport sink (input valid, accepted, left_sample, right_sample, burst_last, underrun,
                fifo_level, playback_ms, output ready);
  modport monitor (input valid, ready, accepted, left_sample, right_sample, burst_last,
                   underrun, fifo_level, playback_ms);
endinterface

interface afg_cfg_if import afg_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
  modport monitor (input valid, ready, index, data);
endinterface

### src/afg_mem.sv
// byte store of the ring fifo, one write and one registered read port
module afg_mem import afg_pkg::*; #(
  parameter int DEPTH = FIFO_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [BYTE_W-1:0]          wdata,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic [BYTE_W-1:0]          rdata
);
  logic [BYTE_W-1:0] store [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      store[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= store[raddr];
  end
endmodule

### src/afg_gain.sv
// two-stage gain unit: q2.14 multiply, truncation toward zero, 16-bit saturation
module afg_gain import afg_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  gain_req_t req,
  output gain_rsp_t rsp
);
  localparam int SCALED_W = GPROD_W - UNITY_FRAC;
  localparam logic signed [GPROD_W-1:0]  ROUND_BIAS = GPROD_W'((1 << UNITY_FRAC) - 1);
  localparam logic signed [SCALED_W-1:0] HI_LIM = SCALED_W'(SAT_MAX);
  localparam logic signed [SCALED_W-1:0] LO_LIM = SCALED_W'(SAT_MIN);

  logic signed [GPROD_W-1:0]  prod;
  logic signed [GPROD_W-1:0]  biased;
  logic signed [SCALED_W-1:0] scaled;
  logic signed [SAMPLE_W-1:0] sat;
  logic signed [SAMPLE_W-1:0] value;
  logic                       p_valid;
  logic                       o_valid;

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      p_valid <= req.valid;
      o_valid <= p_valid;
    end
  end

  // stage one: signed sample times unsigned gain
  always_ff @(posedge clk) begin
    prod <= req.sample * $signed({1'b0, req.gain});
  end

  // stage two: bias negatives so the shift truncates toward zero, then clamp
  always_comb begin
    biased = prod + (prod[GPROD_W-1] ? ROUND_BIAS : '0);
    scaled = biased[GPROD_W-1:UNITY_FRAC];
    if (scaled > HI_LIM) begin
      sat = SAMPLE_W'(SAT_MAX);
    end else if (scaled < LO_LIM) begin
      sat = SAMPLE_W'(SAT_MIN);
    end else begin
      sat = scaled[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    value <= sat;
  end

  assign rsp.valid = o_valid;
  assign rsp.value = value;
endmodule

### src/afg_div.sv
// restoring divider, one quotient bit per cycle, for the playback time
module afg_div import afg_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);
  localparam int CNT_W = $clog2(PROD_W);

  logic [PROD_W-1:0] dvd;
  logic [RATE_W-1:0] dvs;
  logic [RATE_W-1:0] rem;
  logic [MS_W-1:0]   quo;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic              done;
  logic              zero;
  logic [RATE_W:0]   trial;
  logic              fits;

  // shared compare and subtract
  assign trial = {rem, dvd[PROD_W-1]};
  assign fits  = (trial >= {1'b0, dvs});

  // step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == CNT_W'(PROD_W - 1))) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // remainder and quotient shift
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd  <= req.dividend;
      dvs  <= req.divisor;
      rem  <= '0;
      quo  <= '0;
      cnt  <= '0;
      zero <= (req.divisor == '0);
    end else if (busy) begin
      dvd <= {dvd[PROD_W-2:0], 1'b0};
      rem <= fits ? RATE_W'(trial - {1'b0, dvs}) : trial[RATE_W-1:0];
      quo <= {quo[MS_W-2:0], fits};
      cnt <= cnt + 1'b1;
    end
  end

  // a zero rate reads as zero time
  assign rsp.done     = done;
  assign rsp.quotient = zero ? '0 : quo;
endmodule

### src/audio_fifo_with_stereo_gain.sv
// top level of the pcm byte fifo with per-channel gain
//
// cmd carries one action per beat: write a byte, pull a burst of frames or flush.
// res returns one beat per write, flush or empty pull and one beat per frame of a
// pull; burst_last marks the final beat of each command. cfg writes the gain,
// channel count and sample rate registers and is always ready; write it only
// while no command is in flight.
// cmd is taken only when the block is idle. A write or flush shows its result the
// cycle after it is taken. A pull first moves the read pointer past its bytes
// and adds its frames to the frame total, then waits for the shared
// one-bit-per-cycle divider that turns the frame total into milliseconds; after
// that each frame reads its bytes one at a time through the registered store
// read and then takes one gain pass per channel, left then right (an underrun
// skips the gain). After a sample rate change the next command also waits for the
// divider. Reset empties the fifo, clears the frame total and loads the default
// registers; stored bytes are not cleared. While res stalls, the block holds its
// result and takes no further command.
module audio_fifo_with_stereo_gain import afg_pkg::*; #(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF,
  parameter int MAX_BURST  = MAX_BURST_DEF
) (
  input  logic       clk,
  input  logic       rst,
  afg_cmd_if.sink    cmd,
  afg_res_if.source  res,
  afg_cfg_if.sink    cfg
);
  localparam int PTR_W  = $clog2(FIFO_DEPTH);
  localparam int NEED_W = $clog2(4 * MAX_BURST + 1);
  localparam int CMP_W  = (PTR_W > NEED_W) ? PTR_W : NEED_W;
  localparam logic [PTR_W-1:0]    PTR_LAST  = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [CMP_W:0]      DEPTH_EXT = (CMP_W + 1)'(FIFO_DEPTH);
  localparam logic [FRAMES_W-1:0] BURST_MAX = FRAMES_W'(MAX_BURST);

  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_PREP     = 11'b000_0000_0010,
    S_DIV_GO   = 11'b000_0000_0100,
    S_DIV_WAIT = 11'b000_0000_1000,
    S_FETCH    = 11'b000_0001_0000,
    S_BYTE     = 11'b000_0010_0000,
    S_GAIN_L   = 11'b000_0100_0000,
    S_GAIN_LW  = 11'b000_1000_0000,
    S_GAIN_R   = 11'b001_0000_0000,
    S_GAIN_RW  = 11'b010_0000_0000,
    S_OUT      = 11'b100_0000_0000
  } state_t;

  state_t state, state_next;

  // fifo and playback state
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [PTR_W-1:0]  level;
  logic [PROD_W-1:0] prod;
  logic [MS_W-1:0]   ms;
  logic              stale;

  // registers
  logic [GAIN_W-1:0] gain_l;
  logic [GAIN_W-1:0] gain_r;
  logic [CHAN_W-1:0] chan;
  logic [RATE_W-1:0] rate;

  // burst context
  logic [FRAMES_W-1:0] frames;
  logic [FRAMES_W-1:0] fidx;
  logic [NEED_W-1:0]   bidx;
  logic [NEED_W-1:0]   got;
  logic                full;
  logic                stereo;
  logic                is_burst;
  logic [PTR_W-1:0]    cur;
  logic [1:0]          pos;
  logic [BYTE_W-1:0]   fbytes [4];

  // result register
  logic                       out_acc;
  logic signed [SAMPLE_W-1:0] out_left;
  logic signed [SAMPLE_W-1:0] out_right;
  logic                       out_last;
  logic                       out_under;

  // decode of the command beat
  action_t             act_in;
  logic                cmd_take;
  logic                res_take;
  logic [FRAMES_W-1:0] frames_in;
  logic [NEED_W-1:0]   need_in;
  logic [NEED_W-1:0]   got_in;
  logic                full_in;
  logic                burst_in;
  logic                wr_full;
  logic                mem_we;
  logic [PTR_W-1:0]    wr_ptr_inc;
  logic [PTR_W-1:0]    cur_inc;
  logic [CMP_W:0]      rd_sum;
  logic [CMP_W:0]      rd_wrap;
  logic [BYTE_W-1:0]   mem_rd;
  logic [BYTE_W-1:0]   byte_in;
  logic                frame_end;
  logic [SAMPLE_W-1:0] lraw;
  logic [SAMPLE_W-1:0] rraw;

  div_req_t  div_req;
  div_rsp_t  div_rsp;
  gain_req_t g_req;
  gain_rsp_t g_rsp;

  // handshakes
  assign cmd.ready = (state == S_IDLE);
  assign res.valid = (state == S_OUT);
  assign cfg.ready = 1'b1;
  assign cmd_take  = (state == S_IDLE) && cmd.valid;
  assign res_take  = res.valid && res.ready;
  assign act_in    = action_t'(cmd.action);

  // pull sizing: frames clamp, bytes needed, bytes present
  always_comb begin
    frames_in = (cmd.frame_count > BURST_MAX) ? BURST_MAX : cmd.frame_count;
    need_in   = chan[1] ? NEED_W'({frames_in, 2'b00}) : NEED_W'({frames_in, 1'b0});
    full_in   = (CMP_W'(level) >= CMP_W'(need_in));
    got_in    = full_in ? need_in : NEED_W'(level);
    burst_in  = (act_in == ACT_PULL) && (frames_in != '0);
  end

  // pointer arithmetic with wrap at the fifo depth
  always_comb begin
    wr_full    = (level == PTR_LAST);
    wr_ptr_inc = (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
    cur_inc    = (cur == PTR_LAST) ? '0 : cur + 1'b1;
    rd_sum     = (CMP_W + 1)'(rd_ptr) + (CMP_W + 1)'(got);
    rd_wrap    = (rd_sum >= DEPTH_EXT) ? rd_sum - DEPTH_EXT : rd_sum;
  end

  // frame assembly
  assign byte_in   = (bidx < got) ? mem_rd : '0;
  assign frame_end = (pos == {stereo, 1'b1});
  assign lraw      = {fbytes[1], fbytes[0]};
  assign rraw      = stereo ? {fbytes[3], fbytes[2]} : '0;
  assign mem_we    = cmd_take && (act_in == ACT_WRITE) && !wr_full;

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.valid) begin
          if (burst_in) begin
            state_next = S_PREP;
          end else if (stale) begin
            state_next = S_DIV_GO;
          end else begin
            state_next = S_OUT;
          end
        end
      end
      S_PREP:     state_next = S_DIV_GO;
      S_DIV_GO:   state_next = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (div_rsp.done) begin
          state_next = is_burst ? S_FETCH : S_OUT;
        end
      end
      S_FETCH:    state_next = S_BYTE;
      S_BYTE:     state_next = frame_end ? S_GAIN_L : S_FETCH;
      S_GAIN_L:   state_next = full ? S_GAIN_LW : S_OUT;
      S_GAIN_LW: begin
        if (g_rsp.valid) begin
          state_next = stereo ? S_GAIN_R : S_OUT;
        end
      end
      S_GAIN_R:   state_next = S_GAIN_RW;
      S_GAIN_RW: begin
        if (g_rsp.valid) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (res.ready) begin
          state_next = (is_burst && !out_last) ? S_FETCH : S_IDLE;
        end
      end
      default:    state_next = S_IDLE;
    endcase
  end

  // control state, pointers and registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
      prod   <= '0;
      ms     <= '0;
      stale  <= 1'b0;
      gain_l <= GAIN_RESET;
      gain_r <= GAIN_RESET;
      chan   <= CHAN_RESET;
      rate   <= RATE_RESET;
    end else begin
      state <= state_next;
      if (cfg.valid) begin
        unique case (cfg_reg_t'(cfg.index))
          REG_GAIN_LEFT:   gain_l <= cfg.data[GAIN_W-1:0];
          REG_GAIN_RIGHT:  gain_r <= cfg.data[GAIN_W-1:0];
          REG_CHANNELS:    chan   <= cfg.data[CHAN_W-1:0];
          REG_SAMPLE_RATE: begin
            rate  <= cfg.data[RATE_W-1:0];
            stale <= 1'b1;
          end
        endcase
      end
      if (cmd_take) begin
        unique case (act_in)
          ACT_WRITE: begin
            if (!wr_full) begin
              wr_ptr <= wr_ptr_inc;
              level  <= level + 1'b1;
            end
          end
          ACT_FLUSH: begin
            wr_ptr <= '0;
            rd_ptr <= '0;
            level  <= '0;
          end
          ACT_PULL, ACT_NONE: begin
          end
        endcase
      end
      // burst bytes leave the fifo and the frame total grows
      if (state == S_PREP) begin
        rd_ptr <= rd_wrap[PTR_W-1:0];
        level  <= level - PTR_W'(got);
        prod   <= prod + PROD_W'(STEP_W'(frames) * STEP_W'(MS_PER_S));
      end
      if ((state == S_DIV_WAIT) && div_rsp.done) begin
        ms    <= div_rsp.quotient;
        stale <= 1'b0;
      end
    end
  end

  // burst context and result payload
  always_ff @(posedge clk) begin
    if (cmd_take) begin
      out_acc   <= !((act_in == ACT_WRITE) && wr_full);
      out_left  <= '0;
      out_right <= '0;
      out_last  <= 1'b1;
      out_under <= 1'b0;
      is_burst  <= burst_in;
      frames    <= frames_in;
      stereo    <= chan[1];
      got       <= got_in;
      full      <= full_in;
      cur       <= rd_ptr;
      bidx      <= '0;
      pos       <= '0;
      fidx      <= '0;
    end
    if (state == S_BYTE) begin
      fbytes[pos] <= byte_in;
      cur         <= cur_inc;
      bidx        <= bidx + 1'b1;
      pos         <= frame_end ? 2'b00 : pos + 1'b1;
    end
    if (state == S_GAIN_L) begin
      out_acc   <= 1'b1;
      out_last  <= (fidx == frames - 1'b1);
      out_under <= !full;
      if (!full) begin
        out_left  <= lraw;
        out_right <= rraw;
      end
    end
    if ((state == S_GAIN_LW) && g_rsp.valid) begin
      out_left <= g_rsp.value;
      if (!stereo) begin
        out_right <= '0;
      end
    end
    if ((state == S_GAIN_RW) && g_rsp.valid) begin
      out_right <= g_rsp.value;
    end
    if ((state == S_OUT) && res_take) begin
      fidx <= fidx + 1'b1;
    end
  end

  // shared units
  assign div_req.start    = (state == S_DIV_GO);
  assign div_req.dividend = prod;
  assign div_req.divisor  = rate;

  assign g_req.valid  = ((state == S_GAIN_L) && full) || (state == S_GAIN_R);
  assign g_req.sample = (state == S_GAIN_R) ? rraw : lraw;
  assign g_req.gain   = (state == S_GAIN_R) ? gain_r : gain_l;

  afg_mem #(.DEPTH(FIFO_DEPTH)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wr_ptr),
    .wdata (cmd.write_byte),
    .raddr (cur),
    .rdata (mem_rd)
  );

  afg_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  afg_gain u_gain (
    .clk (clk),
    .rst (rst),
    .req (g_req),
    .rsp (g_rsp)
  );

  // result beat
  assign res.accepted     = out_acc;
  assign res.left_sample  = out_left;
  assign res.right_sample = out_right;
  assign res.burst_last   = out_last;
  assign res.underrun     = out_under;
  assign res.fifo_level   = LEVEL_W'(level);
  assign res.playback_ms  = ms;
endmodule

### src/afg_checker.sv
// port-level checks of the pcm fifo block and their binding to the top level
`include "audio_fifo_with_stereo_gain_assert.svh"

module afg_checker import afg_pkg::*; (
  input logic       clk,
  input logic       rst,
  afg_cmd_if.sink   cmd,
  afg_res_if.source res,
  afg_cfg_if.sink   cfg
);
  localparam int PAYLOAD_W = 3 + 2 * SAMPLE_W + LEVEL_W + MS_W;

  logic                 res_take;
  logic                 res_stall;
  logic [PAYLOAD_W-1:0] res_payload;

  // result handshake and payload as one word
  assign res_take    = res.valid && res.ready;
  assign res_stall   = res.valid && !res.ready;
  assign res_payload = {res.accepted, res.left_sample, res.right_sample, res.burst_last,
                        res.underrun, res.fifo_level, res.playback_ms};

  // a taken command leaves commands blocked in the cycle after
  `AFG_ASSERT_NEXT(a_cmd_busy, cmd.valid && cmd.ready, !cmd.ready, "command taken while busy")

  // a burst beat that is not the last keeps commands blocked
  `AFG_ASSERT_NEXT(a_burst_open, res_take && !res.burst_last, !cmd.ready, "command inside a burst")

  // results and commands never overlap
  `AFG_ASSERT_NOW(a_one_side, res.valid, !cmd.ready && cfg.ready, "command ready with a result")

  // a stalled result holds its payload
  `AFG_ASSERT_NEXT(a_res_hold, res_stall, res.valid && $stable(res_payload), "stalled result changed")

  // reset leaves the block idle with no result pending
  `AFG_ASSERT_RST(a_rst_idle, rst, cmd.ready && !res.valid, "block not idle after reset")
endmodule

bind audio_fifo_with_stereo_gain afg_checker u_afg_checker (
  .clk (clk),
  .rst (rst),
  .cmd (cmd),
  .res (res),
  .cfg (cfg)
);

### dv/testbench.sv
// self-checking testbench for the pcm byte fifo with stereo gain
module testbench;
  import afg_pkg::*;

  localparam int RUN_LIMIT   = 60_000_000;
  localparam int PRINT_CAP   = 40;
  localparam int PHASE_ITEMS = 90;
  localparam int BURST_BYTES = MAX_BURST_DEF * 4;

  // one result beat as the block presents it
  typedef struct packed {
    logic                       accepted;
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
    logic                       burst_last;
    logic                       underrun;
    logic [LEVEL_W-1:0]         fifo_level;
    logic [MS_W-1:0]            playback_ms;
  } pcm_beat_t;

  // predicts the result beats of each command and checks the block against them
  class pcm_scoreboard;
    bit [BYTE_W-1:0] store [FIFO_DEPTH_DEF];
    int unsigned     wr_ptr;
    int unsigned     rd_ptr;
    bit [PROD_W-1:0] frames_total;
    bit [GAIN_W-1:0] gain_l;
    bit [GAIN_W-1:0] gain_r;
    bit [CHAN_W-1:0] chans;
    bit [RATE_W-1:0] rate;
    pcm_beat_t       pending [$];
    int              fails;

    function new();
      wr_ptr       = 0;
      rd_ptr       = 0;
      frames_total = '0;
      gain_l       = GAIN_RESET;
      gain_r       = GAIN_RESET;
      chans        = CHAN_RESET;
      rate         = RATE_RESET;
      fails        = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, bit [CFG_DATA_W-1:0] value);
      case (idx)
        REG_GAIN_LEFT:   gain_l = value[GAIN_W-1:0];
        REG_GAIN_RIGHT:  gain_r = value[GAIN_W-1:0];
        REG_CHANNELS:    chans  = value[CHAN_W-1:0];
        REG_SAMPLE_RATE: rate   = value[RATE_W-1:0];
      endcase
    endfunction

    function int unsigned fill();
      return (wr_ptr + FIFO_DEPTH_DEF - rd_ptr) % FIFO_DEPTH_DEF;
    endfunction

    function int unsigned frame_bytes();
      return (chans >= 2) ? 4 : 2;
    endfunction

    // frame total to milliseconds, product wraps at 64 bits
    function bit [MS_W-1:0] play_ms();
      bit [PROD_W-1:0] prod;
      if (rate == 0) return '0;
      prod = frames_total * PROD_W'(MS_PER_S);
      return MS_W'(prod / PROD_W'(rate));
    endfunction

    // q2.14 gain, truncation toward zero, then clamp to 16 bits
    function bit [SAMPLE_W-1:0] scale(bit [SAMPLE_W-1:0] raw, bit [GAIN_W-1:0] g);
      longint s;
      longint v;
      s = longint'($signed(raw));
      v = (s * longint'(g)) / (longint'(1) << UNITY_FRAC);
      if (v > SAT_MAX) v = SAT_MAX;
      if (v < SAT_MIN) v = SAT_MIN;
      return SAMPLE_W'(v);
    endfunction

    function void queue_beat(bit acc, bit [SAMPLE_W-1:0] l, bit [SAMPLE_W-1:0] r,
                             bit last, bit und);
      pcm_beat_t b;
      b.accepted     = acc;
      b.left_sample  = l;
      b.right_sample = r;
      b.burst_last   = last;
      b.underrun     = und;
      b.fifo_level   = LEVEL_W'(fill());
      b.playback_ms  = play_ms();
      pending.push_back(b);
    endfunction

    // called once per accepted command beat
    function void note_cmd(action_t act, bit [BYTE_W-1:0] data, bit [FRAMES_W-1:0] count);
      int unsigned     nxt;
      int unsigned     frames;
      int unsigned     bpf;
      int unsigned     need;
      int unsigned     got;
      int unsigned     base;
      bit [BYTE_W-1:0] burst [BURST_BYTES];
      bit              stereo;
      bit              whole;
      bit [SAMPLE_W-1:0] lraw;
      bit [SAMPLE_W-1:0] rraw;
      case (act)
        ACT_WRITE: begin
          nxt = (wr_ptr + 1) % FIFO_DEPTH_DEF;
          if (nxt != rd_ptr) begin
            store[wr_ptr] = data;
            wr_ptr = nxt;
            queue_beat(1'b1, '0, '0, 1'b1, 1'b0);
          end else begin
            queue_beat(1'b0, '0, '0, 1'b1, 1'b0);
          end
        end
        ACT_PULL: begin
          frames = (count > MAX_BURST_DEF) ? MAX_BURST_DEF : count;
          if (frames == 0) begin
            queue_beat(1'b1, '0, '0, 1'b1, 1'b0);
          end else begin
            stereo = (chans >= 2);
            bpf    = stereo ? 4 : 2;
            need   = frames * bpf;
            got    = fill();
            if (got > need) got = need;
            foreach (burst[i]) burst[i] = '0;
            for (int i = 0; i < got; i++) begin
              burst[i] = store[rd_ptr];
              rd_ptr = (rd_ptr + 1) % FIFO_DEPTH_DEF;
            end
            whole = (got == need);
            frames_total += frames;
            // gain only when the whole burst was there
            for (int f = 0; f < frames; f++) begin
              base = f * bpf;
              lraw = {burst[base + 1], burst[base]};
              rraw = stereo ? {burst[base + 3], burst[base + 2]} : '0;
              if (whole)
                queue_beat(1'b1, scale(lraw, gain_l), stereo ? scale(rraw, gain_r) : '0,
                           f + 1 == frames, 1'b0);
              else
                queue_beat(1'b1, lraw, rraw, f + 1 == frames, 1'b1);
            end
          end
        end
        default: begin
          if (act == ACT_FLUSH) begin
            wr_ptr = 0;
            rd_ptr = 0;
          end
          queue_beat(1'b1, '0, '0, 1'b1, 1'b0);
        end
      endcase
    endfunction

    task report(string msg);
      fails++;
      if (fails <= PRINT_CAP) $display("%0t mismatch: %s", $time, msg);
    endtask

    task compare(string name, logic [63:0] seen, logic [63:0] want);
      if (seen !== want) report($sformatf("%s got %0h want %0h", name, seen, want));
    endtask

    task check(pcm_beat_t seen);
      pcm_beat_t want;
      if (pending.size() == 0) begin
        report("result beat with nothing pending");
      end else begin
        want = pending.pop_front();
        compare("accepted", seen.accepted, want.accepted);
        compare("left_sample", seen.left_sample, want.left_sample);
        compare("right_sample", seen.right_sample, want.right_sample);
        compare("burst_last", seen.burst_last, want.burst_last);
        compare("underrun", seen.underrun, want.underrun);
        compare("fifo_level", seen.fifo_level, want.fifo_level);
        compare("playback_ms", seen.playback_ms, want.playback_ms);
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  int   send_idle = 0;
  int   recv_idle = 0;
  pcm_scoreboard sb = new();

  afg_cmd_if cmd_ch ();
  afg_res_if res_ch ();
  afg_cfg_if cfg_ch ();

  audio_fifo_with_stereo_gain dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // one command beat, with a random gap in front
  task automatic send_cmd(action_t act, logic [BYTE_W-1:0] data, logic [FRAMES_W-1:0] count);
    while ($urandom_range(99) < send_idle) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid       <= 1'b1;
    cmd_ch.action      <= act;
    cmd_ch.write_byte  <= data;
    cmd_ch.frame_count <= count;
    do @(posedge clk); while (cmd_ch.ready !== 1'b1);
    sb.note_cmd(act, data, count);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    sb.set_reg(idx, value);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(logic [CFG_DATA_W-1:0] gl, logic [CFG_DATA_W-1:0] gr,
                                logic [CFG_DATA_W-1:0] ch, logic [CFG_DATA_W-1:0] sr);
    write_reg(REG_GAIN_LEFT, gl);
    write_reg(REG_GAIN_RIGHT, gr);
    write_reg(REG_CHANNELS, ch);
    write_reg(REG_SAMPLE_RATE, sr);
  endtask

  // stop sending and let every pending beat come back
  task automatic settle();
    cmd_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // mostly whole frames and a pull, else stray bytes, odd pulls, flushes, unused actions
  task automatic run_random(int unsigned quota);
    int unsigned issued;
    int unsigned pick;
    int unsigned frames;
    int unsigned n_bytes;
    issued = 0;
    while (issued < quota) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        frames  = ($urandom_range(7) == 0) ? $urandom_range(5, 16) : $urandom_range(1, 4);
        n_bytes = frames * sb.frame_bytes();
        repeat (n_bytes) send_cmd(ACT_WRITE, BYTE_W'($urandom), FRAMES_W'($urandom));
        send_cmd(ACT_PULL, BYTE_W'($urandom), FRAMES_W'($urandom_range(1, frames)));
        issued += n_bytes + 1;
      end else if (pick < 72) begin
        n_bytes = $urandom_range(1, 3);
        repeat (n_bytes) send_cmd(ACT_WRITE, BYTE_W'($urandom), FRAMES_W'($urandom));
        issued += n_bytes;
      end else if (pick < 88) begin
        send_cmd(ACT_PULL, BYTE_W'($urandom), FRAMES_W'($urandom));
        issued++;
      end else if (pick < 95) begin
        send_cmd(ACT_FLUSH, BYTE_W'($urandom), FRAMES_W'($urandom));
        issued++;
      end else begin
        send_cmd(ACT_NONE, BYTE_W'($urandom), FRAMES_W'($urandom));
        issued++;
      end
    end
  endtask

  // result side: random stalls, every beat checked
  initial begin
    pcm_beat_t seen;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst === 1'b0 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
        seen.accepted     = res_ch.accepted;
        seen.left_sample  = res_ch.left_sample;
        seen.right_sample = res_ch.right_sample;
        seen.burst_last   = res_ch.burst_last;
        seen.underrun     = res_ch.underrun;
        seen.fifo_level   = res_ch.fifo_level;
        seen.playback_ms  = res_ch.playback_ms;
        sb.check(seen);
      end
      res_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // stimulus
  initial begin
    logic [BYTE_W-1:0] extremes [8] = '{8'h00, 8'h80, 8'hFF, 8'h7F, 8'hFF, 8'hFF, 8'h01, 8'h00};
    logic [BYTE_W-1:0] partial [4]  = '{8'h34, 8'h12, 8'hCD, 8'hAB};
    rst                <= 1'b1;
    cmd_ch.valid       <= 1'b0;
    cmd_ch.action      <= ACT_WRITE;
    cmd_ch.write_byte  <= '0;
    cmd_ch.frame_count <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= REG_GAIN_LEFT;
    cfg_ch.data        <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_idle = 33;
    recv_idle = 75;

    // directed: empty pulls, unused action, full-scale samples at unity gain
    send_cmd(ACT_PULL, '0, '0);
    send_cmd(ACT_PULL, '0, FRAMES_W'(1));
    send_cmd(ACT_NONE, 8'hFF, 7'h7F);
    foreach (extremes[i]) send_cmd(ACT_WRITE, extremes[i], '0);
    send_cmd(ACT_PULL, '0, FRAMES_W'(2));
    // short burst passes raw bytes, missing frame reads as zero
    foreach (partial[i]) send_cmd(ACT_WRITE, partial[i], '0);
    send_cmd(ACT_PULL, '0, FRAMES_W'(2));
    // flush drops held bytes
    send_cmd(ACT_WRITE, 8'h55, '0);
    send_cmd(ACT_WRITE, 8'hAA, '0);
    send_cmd(ACT_FLUSH, '0, '0);
    send_cmd(ACT_PULL, '0, FRAMES_W'(1));
    // oversized pull clipped to the burst limit
    send_cmd(ACT_PULL, '0, 7'h7F);
    settle();

    // mono, maximum left gain, lowest rate
    apply_settings(18'd65535, 18'd0, 18'd1, 18'd8000);
    run_random(PHASE_ITEMS);
    settle();

    // odd stereo code, maximum right gain, highest rate
    send_idle = 75;
    recv_idle = 33;
    apply_settings(18'd0, 18'd65535, 18'd3, 18'd192000);
    run_random(PHASE_ITEMS);
    settle();

    // zero channel code reads as mono, zero rate gives zero time
    send_idle = 0;
    recv_idle = 0;
    apply_settings(CFG_DATA_W'($urandom_range(65535)), CFG_DATA_W'($urandom_range(65535)),
                   18'd0, 18'd0);
    run_random(PHASE_ITEMS);
    settle();
    repeat (200) @(posedge clk);

    if (sb.fails == 0 && sb.pending.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // hang guard
  initial begin
    #(RUN_LIMIT);
    $display("testbench NOT OK");
    $finish;
  end

endmodule
